/* hw/rtl/eap_pkg.sv */
// Package for the extent address allocator.
// Holds the request and result types, the table entry and cell control types,
// and the opcode, status and register index codes. No dependencies.
`default_nettype none
package eap_pkg;

  localparam int unsigned MAX_EXTENTS = 64;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RECORD = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNINIT    = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd5;
  localparam logic [2:0] ST_BAD_LEN   = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  localparam logic REG_REGION_BASE   = 1'b0;
  localparam logic REG_REGION_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] address;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] result_address;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;

  // Update command for one cell; at most one of these is set.
  typedef struct packed {
    logic wr;   // take the primary new entry
    logic ins;  // take the inserted new entry
    logic shr;  // take the entry of the cell below (insert shift)
    logic shl;  // take the entry of the cell above (erase shift)
  } cell_ctrl_t;

  // Per-cell search results, latched in the evaluation cycle.
  typedef struct packed {
    logic gap;    // gap after this entry fits the request
    logic close;  // allocation closes that gap exactly
    logic hit;    // free offset lies in [start, start + len]
    logic above;  // start lies above the record offset
  } cell_flag_t;

endpackage
`default_nettype wire

/* hw/rtl/eap_cell.sv */
// One cell of the extent table chain: holds one entry and its search flags.
// Depends on eap_pkg for the entry, control and flag types.
`default_nettype none
module eap_cell (
  input  wire                  clk_i,
  input  wire                  eval_i,
  input  wire                  valid_i,
  input  wire                  nvalid_i,
  input  eap_pkg::entry_t      prev_i,
  input  eap_pkg::entry_t      next_i,
  input  wire [31:0]           len_i,
  input  wire [31:0]           off_i,
  input  wire [31:0]           rec_i,
  input  eap_pkg::cell_ctrl_t  ctrl_i,
  input  eap_pkg::entry_t      new_a_i,
  input  eap_pkg::entry_t      new_b_i,
  output eap_pkg::entry_t      entry_o,
  output eap_pkg::cell_flag_t  flag_o
);

  eap_pkg::entry_t     entry_q, entry_d;
  eap_pkg::cell_flag_t flag_q, flag_d;
  logic [32:0]         end_w;
  logic [32:0]         nx_w;

  assign end_w = {1'b0, entry_q.start} + {1'b0, entry_q.len};
  assign nx_w  = {1'b0, next_i.start};

  always_comb begin
    flag_d.gap   = nvalid_i && (nx_w >= end_w) && ((nx_w - end_w) >= {1'b0, len_i});
    flag_d.close = ({1'b0, end_w} + {2'b0, len_i}) == {1'b0, nx_w};
    flag_d.hit   = valid_i && (off_i >= entry_q.start) && ({1'b0, off_i} <= end_w);
    flag_d.above = valid_i && (entry_q.start > rec_i);
  end

  always_comb begin
    priority if (ctrl_i.shr) begin
      entry_d = prev_i;
    end else if (ctrl_i.shl) begin
      entry_d = next_i;
    end else if (ctrl_i.wr) begin
      entry_d = new_a_i;
    end else if (ctrl_i.ins) begin
      entry_d = new_b_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (eval_i) begin
      flag_q <= flag_d;
    end
  end

  assign entry_o = entry_q;
  assign flag_o  = flag_q;

endmodule
`default_nettype wire

/* hw/rtl/extent_address_allocator.sv */
// First-fit extent allocator over a chain of table cells, one sorted entry per cell.
// A request passes through capture, evaluation of all cells in parallel, first-match
// selection, and the update in which every cell loads its own, its lower or its upper
// neighbor's entry; the update waits while the output register is held. One request
// is in work at a time; the next is accepted while a result waits in that register.
// Depends on eap_pkg and eap_cell.
`default_nettype none
module extent_address_allocator #(
  parameter int unsigned MaxExtents = eap_pkg::MAX_EXTENTS
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            cfg_we_i,
  input  wire  [0:0]     cfg_idx_i,
  input  wire  [63:0]    cfg_wdata_i,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  eap_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output eap_pkg::rsp_t  out_rsp_o
);

  localparam int unsigned CntW = $clog2(MaxExtents + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxExtents);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_PICK  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  localparam logic [MaxExtents-1:0] Bit0 = MaxExtents'(1);

  logic [1:0]      state_q, state_d;
  logic [63:0]     base_q;
  logic [31:0]     rlen_q;
  logic [CntW-1:0] count_q, count_d;

  eap_pkg::req_t req_q;
  logic [31:0]   off_q;
  logic          rng_bad_q, rec_bad_q;

  logic          out_valid_q;
  eap_pkg::rsp_t out_q;

  eap_pkg::entry_t     entries [MaxExtents];
  eap_pkg::cell_flag_t flags   [MaxExtents];
  eap_pkg::cell_ctrl_t ctrl    [MaxExtents];
  eap_pkg::entry_t     new_a, new_b;

  logic [MaxExtents-1:0] valid_v, gap_v, close_v, hit_v, above_v, last_oh;
  logic [MaxExtents-1:0] gap_oh_q, hit_oh_q, rec_oh_q;
  logic                  close_q;
  logic [MaxExtents-1:0] wr_v, ins_v, shr_v, shl_v;

  logic in_fire, out_free, apply_fire, full;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign apply_fire = (state_q == S_APPLY) && out_free;
  assign full       = (count_q == CntMax);

  // Cell chain.
  for (genvar i = 0; i < MaxExtents; i++) begin : g_cell
    assign valid_v[i] = (CntW'(i) < count_q);
    assign gap_v[i]   = flags[i].gap;
    assign close_v[i] = flags[i].close;
    assign hit_v[i]   = flags[i].hit;
    assign above_v[i] = flags[i].above;
    assign ctrl[i]    = '{wr: wr_v[i], ins: ins_v[i], shr: shr_v[i], shl: shl_v[i]};

    eap_pkg::entry_t prev_w, next_w;
    logic            nvalid_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = entries[i-1];
    end
    if (i == MaxExtents - 1) begin : g_top
      assign next_w   = '0;
      assign nvalid_w = 1'b0;
    end else begin : g_low
      assign next_w   = entries[i+1];
      assign nvalid_w = valid_v[i+1];
    end

    eap_cell u_cell (
      .clk_i    (clk_i),
      .eval_i   (state_q == S_EVAL),
      .valid_i  (valid_v[i]),
      .nvalid_i (nvalid_w),
      .prev_i   (prev_w),
      .next_i   (next_w),
      .len_i    (req_q.length),
      .off_i    (off_q),
      .rec_i    (req_q.address[31:0]),
      .ctrl_i   (ctrl[i]),
      .new_a_i  (new_a),
      .new_b_i  (new_b),
      .entry_o  (entries[i]),
      .flag_o   (flags[i])
    );
  end

  assign last_oh = valid_v & ~(valid_v >> 1);

  function automatic eap_pkg::entry_t gather(input logic [MaxExtents-1:0] oh,
                                             input eap_pkg::entry_t arr [MaxExtents]);
    eap_pkg::entry_t r;
    r = '0;
    for (int k = 0; k < MaxExtents; k++) begin
      r = r | (arr[k] & {64{oh[k]}});
    end
    return r;
  endfunction

  eap_pkg::entry_t g_gap, g_gapn, g_hit, g_last, e0;
  assign g_gap  = gather(gap_oh_q, entries);
  assign g_gapn = gather(gap_oh_q << 1, entries);
  assign g_hit  = gather(hit_oh_q, entries);
  assign g_last = gather(last_oh, entries);
  assign e0     = entries[0];

  logic [2:0]            st;
  logic [63:0]           res_addr;
  logic [32:0]           gap_end, hit_end, last_end;
  logic [31:0]           head, rest;
  logic [MaxExtents-1:0] pos_oh;

  assign gap_end  = {1'b0, g_gap.start} + {1'b0, g_gap.len};
  assign hit_end  = {1'b0, g_hit.start} + {1'b0, g_hit.len};
  assign last_end = {1'b0, g_last.start} + {1'b0, g_last.len};
  assign head     = off_q - g_hit.start;
  assign rest     = g_hit.len - head - req_q.length;

  always_comb begin
    st       = eap_pkg::ST_OK;
    res_addr = '0;
    wr_v     = '0;
    ins_v    = '0;
    shr_v    = '0;
    shl_v    = '0;
    new_a    = '0;
    new_b    = '0;
    count_d  = count_q;
    pos_oh   = '0;
    unique case (req_q.opcode)
      eap_pkg::OP_ALLOC: begin
        if (base_q == 64'd0) begin
          st = eap_pkg::ST_UNINIT;
        end else if (req_q.length > rlen_q) begin
          st = eap_pkg::ST_TOO_LONG;
        end else if (req_q.length == 32'd0) begin
          st = eap_pkg::ST_BAD_LEN;
        end else if (count_q == '0 || req_q.length < e0.start) begin
          if (count_q != '0 && full) begin
            st = eap_pkg::ST_FULL;
          end else begin
            ins_v    = Bit0;
            shr_v    = ~(Bit0 | (Bit0 - 1'b1));
            new_b    = '{start: 32'd0, len: req_q.length};
            count_d  = count_q + 1'b1;
            res_addr = base_q;
          end
        end else if (req_q.length == e0.start) begin
          wr_v     = Bit0;
          new_a    = '{start: 32'd0, len: e0.len + req_q.length};
          res_addr = base_q;
        end else if (gap_oh_q != '0) begin
          wr_v  = gap_oh_q;
          new_a = '{start: g_gap.start,
                    len: g_gap.len + req_q.length + (close_q ? g_gapn.len : 32'd0)};
          if (close_q) begin
            // The gap is filled exactly: merge with the following extent.
            shl_v   = ~(gap_oh_q | (gap_oh_q - 1'b1));
            count_d = count_q - 1'b1;
          end
          res_addr = base_q + 64'(gap_end);
        end else if (({1'b0, last_end} + {2'b0, req_q.length}) > {2'b0, rlen_q}) begin
          st = eap_pkg::ST_NO_SPACE;
        end else begin
          wr_v     = last_oh;
          new_a    = '{start: g_last.start, len: g_last.len + req_q.length};
          res_addr = base_q + 64'(last_end);
        end
      end
      eap_pkg::OP_FREE: begin
        if (rng_bad_q) begin
          st = eap_pkg::ST_RANGE;
        end else if (hit_oh_q == '0) begin
          st = eap_pkg::ST_NOT_ALLOC;
        end else if (off_q == g_hit.start) begin
          if (req_q.length == g_hit.len) begin
            shl_v   = ~(hit_oh_q - 1'b1);
            count_d = count_q - 1'b1;
          end else if (req_q.length < g_hit.len) begin
            wr_v  = hit_oh_q;
            new_a = '{start: g_hit.start + req_q.length, len: g_hit.len - req_q.length};
          end else begin
            st = eap_pkg::ST_BAD_LEN;
          end
        end else if (({1'b0, off_q} + {1'b0, req_q.length}) > hit_end) begin
          st = eap_pkg::ST_BAD_LEN;
        end else if (rest != 32'd0 && full) begin
          st = eap_pkg::ST_FULL;
        end else begin
          // Keep the head; a remaining tail becomes a new entry right above.
          wr_v  = hit_oh_q;
          new_a = '{start: g_hit.start, len: head};
          if (rest != 32'd0) begin
            pos_oh  = hit_oh_q << 1;
            ins_v   = pos_oh;
            shr_v   = ~(pos_oh | (pos_oh - 1'b1));
            new_b   = '{start: off_q + req_q.length, len: rest};
            count_d = count_q + 1'b1;
          end
        end
      end
      eap_pkg::OP_RECORD: begin
        if (req_q.length == 32'd0) begin
          st = eap_pkg::ST_BAD_LEN;
        end else if (rec_bad_q) begin
          st = eap_pkg::ST_RANGE;
        end else if (full) begin
          st = eap_pkg::ST_FULL;
        end else begin
          if (rec_oh_q != '0) begin
            pos_oh = rec_oh_q;
          end else if (count_q == '0) begin
            pos_oh = Bit0;
          end else begin
            pos_oh = last_oh << 1;
          end
          ins_v   = pos_oh;
          shr_v   = ~(pos_oh | (pos_oh - 1'b1));
          new_b   = '{start: req_q.address[31:0], len: req_q.length};
          count_d = count_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!apply_fire) begin
      wr_v  = '0;
      ins_v = '0;
      shr_v = '0;
      shl_v = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EVAL;
      S_EVAL:  state_d = S_PICK;
      S_PICK:  state_d = S_APPLY;
      S_APPLY: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      base_q      <= '0;
      rlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          eap_pkg::REG_REGION_BASE:   base_q <= cfg_wdata_i;
          eap_pkg::REG_REGION_LENGTH: rlen_q <= cfg_wdata_i[31:0];
          default: begin
          end
        endcase
      end
      if (apply_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q     <= in_req_i;
      off_q     <= in_req_i.address[31:0] - base_q[31:0];
      rng_bad_q <= (in_req_i.address < base_q) ||
                   ((in_req_i.address - base_q) > {32'd0, rlen_q});
      rec_bad_q <= (in_req_i.address[63:32] != 32'd0) ||
                   (({1'b0, in_req_i.address[31:0]} + {1'b0, in_req_i.length}) >
                    {1'b0, rlen_q});
    end
    if (state_q == S_PICK) begin
      gap_oh_q <= gap_v & (~gap_v + 1'b1);
      hit_oh_q <= hit_v & (~hit_v + 1'b1);
      rec_oh_q <= above_v & (~above_v + 1'b1);
      close_q  <= |((gap_v & (~gap_v + 1'b1)) & close_v);
    end
    if (apply_fire) begin
      out_q <= '{status: st, result_address: (st == eap_pkg::ST_OK) ? res_addr : 64'd0};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("extent count above table size");

  a_count_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !apply_fire |=> $stable(count_q)) else $error("count changed outside update");

  a_out_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_APPLY)) else $error("result without update");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != eap_pkg::ST_OK) |-> out_rsp_o.result_address == 64'd0)
    else $error("failed request returned an address");

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the first-fit extent address allocator.
// Drives requests and register writes, predicts every result with its own table model.
// Depends on eap_pkg and the extent_address_allocator RTL.
`timescale 1ns / 100ps
module tb;

  localparam int unsigned STALL_LIMIT = 2000;
  // Opcode three has no function; the block answers it with status ok.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  class extent_scoreboard;
    logic [63:0] base;
    logic [31:0] region_len;
    logic [31:0] ext_start [eap_pkg::MAX_EXTENTS];
    logic [31:0] ext_len [eap_pkg::MAX_EXTENTS];
    int unsigned used;
    eap_pkg::rsp_t pending_rsp[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned status_seen [8];

    function void init();
      base = '0;
      region_len = '0;
      used = 0;
      errors = 0;
      checked = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [63:0] data);
      if (idx == eap_pkg::REG_REGION_BASE) base = data;
      else region_len = data[31:0];
    endfunction

    function void put(int unsigned pos, logic [31:0] s, logic [31:0] l);
      for (int unsigned k = used; k > pos; k--) begin
        ext_start[k] = ext_start[k-1];
        ext_len[k] = ext_len[k-1];
      end
      ext_start[pos] = s;
      ext_len[pos] = l;
      used++;
    endfunction

    function void drop(int unsigned pos);
      for (int unsigned k = pos; k + 1 < used; k++) begin
        ext_start[k] = ext_start[k+1];
        ext_len[k] = ext_len[k+1];
      end
      used--;
    endfunction

    function logic [2:0] allocate(logic [31:0] len, output logic [63:0] addr);
      logic [63:0] nx, e;
      logic [31:0] nl;
      int unsigned last;
      addr = '0;
      if (base == 0) return eap_pkg::ST_UNINIT;
      if (len > region_len) return eap_pkg::ST_TOO_LONG;
      if (len == 0) return eap_pkg::ST_BAD_LEN;
      if (used == 0 || len < ext_start[0]) begin
        if (used >= eap_pkg::MAX_EXTENTS) return eap_pkg::ST_FULL;
        put(0, '0, len);
        addr = base;
        return eap_pkg::ST_OK;
      end
      if (len == ext_start[0]) begin
        ext_start[0] = '0;
        ext_len[0] = ext_len[0] + len;
        addr = base;
        return eap_pkg::ST_OK;
      end
      for (int unsigned i = 0; i + 1 < used; i++) begin
        nx = 64'(ext_start[i+1]);
        e = 64'(ext_start[i]) + 64'(ext_len[i]);
        if (nx >= e && nx - e >= 64'(len)) begin
          nl = ext_len[i] + len;
          // The new piece closes the gap exactly, so the next extent joins this one.
          if (e + 64'(len) == nx) begin
            nl = nl + ext_len[i+1];
            drop(i + 1);
          end
          ext_len[i] = nl;
          addr = base + e;
          return eap_pkg::ST_OK;
        end
      end
      last = used - 1;
      e = 64'(ext_start[last]) + 64'(ext_len[last]);
      if (e + 64'(len) > 64'(region_len)) return eap_pkg::ST_NO_SPACE;
      ext_len[last] = ext_len[last] + len;
      addr = base + e;
      return eap_pkg::ST_OK;
    endfunction

    function logic [2:0] release_units(logic [63:0] address, logic [31:0] len);
      logic [31:0] off, s, l, head, rest;
      logic [63:0] e;
      int unsigned i;
      if (address < base || address - base > 64'(region_len)) return eap_pkg::ST_RANGE;
      off = 32'(address - base);
      for (i = 0; i < used; i++)
        if (off >= ext_start[i] && 64'(off) <= 64'(ext_start[i]) + 64'(ext_len[i])) break;
      if (i >= used) return eap_pkg::ST_NOT_ALLOC;
      s = ext_start[i];
      l = ext_len[i];
      e = 64'(s) + 64'(l);
      if (off == s) begin
        if (len == l) drop(i);
        else if (len < l) begin
          ext_start[i] = s + len;
          ext_len[i] = l - len;
        end else return eap_pkg::ST_BAD_LEN;
        return eap_pkg::ST_OK;
      end
      if (64'(off) + 64'(len) > e) return eap_pkg::ST_BAD_LEN;
      head = off - s;
      rest = l - head - len;
      if (rest > 0 && used >= eap_pkg::MAX_EXTENTS) return eap_pkg::ST_FULL;
      ext_len[i] = head;
      if (rest > 0) put(i + 1, off + len, rest);
      return eap_pkg::ST_OK;
    endfunction

    function logic [2:0] record_extent(logic [63:0] address, logic [31:0] len);
      int unsigned pos;
      if (len == 0) return eap_pkg::ST_BAD_LEN;
      if (address > 64'hFFFF_FFFF || address + 64'(len) > 64'(region_len))
        return eap_pkg::ST_RANGE;
      if (used >= eap_pkg::MAX_EXTENTS) return eap_pkg::ST_FULL;
      for (pos = 0; pos < used; pos++)
        if (64'(ext_start[pos]) > address) break;
      put(pos, address[31:0], len);
      return eap_pkg::ST_OK;
    endfunction

    function void note_request(eap_pkg::req_t req);
      eap_pkg::rsp_t exp;
      exp = '0;
      case (req.opcode)
        eap_pkg::OP_ALLOC: exp.status = allocate(req.length, exp.result_address);
        eap_pkg::OP_FREE: exp.status = release_units(req.address, req.length);
        eap_pkg::OP_RECORD: exp.status = record_extent(req.address, req.length);
        default: exp.status = eap_pkg::ST_OK;
      endcase
      if (exp.status != eap_pkg::ST_OK) exp.result_address = '0;
      pending_rsp = {pending_rsp, exp};
    endfunction

    function void check_result(eap_pkg::rsp_t act);
      eap_pkg::rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result status %0d address %h", $time, act.status,
                 act.result_address);
        errors++;
        return;
      end
      exp = pending_rsp.pop_front();
      checked++;
      status_seen[exp.status]++;
      if (act.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, act.status);
        errors++;
      end
      if (act.result_address !== exp.result_address) begin
        $display("%0t: address expected %h actual %h", $time, exp.result_address,
                 act.result_address);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  eap_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  eap_pkg::rsp_t out_rsp_o;

  extent_scoreboard sb;
  bit no_idle = 1'b0;
  int unsigned long_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent = 0;

  always #1 clk_i = ~clk_i;

  extent_address_allocator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o
  );

  // Both channels are observed here; values sampled at the edge are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 15);
      if (long_hold > 0) begin
        wait_cycles = long_hold;
        long_hold = 0;
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send(eap_pkg::req_t req);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_fields(logic [1:0] op, logic [63:0] address, logic [31:0] len);
    eap_pkg::req_t req;
    req.opcode = op;
    req.address = address;
    req.length = len;
    send(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic set_region(logic [63:0] base, logic [31:0] len);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= eap_pkg::REG_REGION_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_idx_i <= eap_pkg::REG_REGION_LENGTH;
    cfg_wdata_i <= {$urandom(), len};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(eap_pkg::REG_REGION_BASE, base);
    sb.set_reg(eap_pkg::REG_REGION_LENGTH, 64'(len));
  endtask

  function automatic eap_pkg::req_t random_request();
    eap_pkg::req_t req;
    int unsigned pick, i;
    logic [31:0] off;
    req.address = {$urandom(), $urandom()};
    req.length = $urandom_range(0, 12);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      req.opcode = eap_pkg::OP_ALLOC;
      if ($urandom_range(0, 9) == 0) req.length = $urandom();
    end else if (pick < 70) begin
      req.opcode = eap_pkg::OP_FREE;
      if (sb.used > 0) begin
        i = $urandom_range(0, sb.used - 1);
        off = sb.ext_start[i] + $urandom_range(0, sb.ext_len[i] > 8 ? 8 : sb.ext_len[i]);
        if ($urandom_range(0, 1)) req.length = sb.ext_start[i] + sb.ext_len[i] - off;
        req.address = sb.base + 64'(off);
      end
    end else if (pick < 92) begin
      req.opcode = eap_pkg::OP_RECORD;
      req.address = 64'($urandom_range(0, sb.region_len > 600 ? 600 : sb.region_len));
      if ($urandom_range(0, 19) == 0) req.address = {$urandom(), $urandom()};
    end else if (pick < 95) begin
      req.opcode = OP_UNKNOWN;
    end else begin
      req.opcode = 2'($urandom_range(0, 3));
      req.length = $urandom();
    end
    return req;
  endfunction

  task automatic random_phase(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send(random_request());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [63:0] b;
    sb = new();
    sb.init();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Region not set up: allocate answers uninitialised; free and record do not check for it.
    send_fields(eap_pkg::OP_ALLOC, '0, 32'd4);
    send_fields(eap_pkg::OP_FREE, 64'd0, 32'd0);
    send_fields(eap_pkg::OP_RECORD, 64'd0, 32'd1);
    send_fields(OP_UNKNOWN, '1, '1);

    set_region(64'h1000, 32'd1000);
    b = 64'h1000;
    send_fields(eap_pkg::OP_FREE, b, 32'd1);
    send_fields(eap_pkg::OP_ALLOC, '1, 32'd0);
    send_fields(eap_pkg::OP_ALLOC, '0, 32'd2000);
    send_fields(eap_pkg::OP_ALLOC, '0, '1);
    send_fields(eap_pkg::OP_ALLOC, '0, 32'd10);
    send_fields(eap_pkg::OP_RECORD, 64'd100, 32'd10);
    send_fields(eap_pkg::OP_ALLOC, '0, 32'd90);
    send_fields(eap_pkg::OP_FREE, b, 32'd3);
    send_fields(eap_pkg::OP_ALLOC, '0, 32'd1);
    send_fields(eap_pkg::OP_ALLOC, '0, 32'd2);
    send_fields(eap_pkg::OP_FREE, b + 64'd5, 32'd2);
    send_fields(eap_pkg::OP_FREE, b - 64'd1, 32'd1);
    send_fields(eap_pkg::OP_FREE, b + 64'd1001, 32'd1);
    send_fields(eap_pkg::OP_FREE, b + 64'd900, 32'd1);
    send_fields(eap_pkg::OP_FREE, b + 64'd50, 32'd0);
    send_fields(eap_pkg::OP_FREE, b + 64'd50, 32'd5000);
    send_fields(eap_pkg::OP_RECORD, 64'h1_0000_0000, 32'd1);
    send_fields(eap_pkg::OP_RECORD, 64'd990, 32'd20);
    send_fields(eap_pkg::OP_RECORD, 64'd300, 32'd0);
    send_fields(eap_pkg::OP_ALLOC, '0, 32'd1000);
    send_fields(eap_pkg::OP_FREE, '1, '1);

    // Small region so the table fills and space runs out.
    set_region({$urandom(), $urandom()} | 64'd1, 32'd400);
    random_phase(250);

    // Receiver holds off while the sender keeps pushing.
    long_hold = 300;
    no_idle = 1'b1;
    for (int unsigned n = 0; n < 20; n++) send(random_request());
    no_idle = 1'b0;
    drain();
    random_phase(150);

    // Base near the top of the address space: result addresses wrap.
    set_region(64'hFFFF_FFFF_FFFF_FFC0, '1);
    random_phase(200);
    set_region(64'd1, 32'd0);
    random_phase(60);
    set_region('1, 32'd5000);
    random_phase(200);
    set_region('0, 32'd100);
    random_phase(40);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests over six region settings, %0d results checked.", sent,
             sb.checked);
    $display("Status counts ok %0d, no space %0d, table full %0d, range %0d.",
             sb.status_seen[eap_pkg::ST_OK], sb.status_seen[eap_pkg::ST_NO_SPACE],
             sb.status_seen[eap_pkg::ST_FULL], sb.status_seen[eap_pkg::ST_RANGE]);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
